// ===== rtl/core/ple_pkg.sv =====
// Package for the positional list engine: request and response payloads,
// operation and status codes, controller states and the command/status structs.
// No dependencies.
package ple_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int WORD_W       = 32;
  localparam int POS_W        = 5;
  localparam int COUNT_W      = 5;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_REPLACE = 2'd1,
    OP_INSERT  = 2'd2,
    OP_DELETE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                op;
    logic [POS_W-1:0]   position;
    logic signed [WORD_W-1:0] word_in;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word_out;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_req;
    logic    init_k;
    logic    rd_issue;
    logic    rd_sel_shift;
    logic    shift_write;
    logic    k_step;
    logic    word_write;
    logic    count_inc;
    logic    count_dec;
    logic    set_status;
    status_t status_code;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic range_err;
    logic full_err;
    logic more;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/ple_ctrl.sv =====
// Controller of the positional list engine: sequences checks, shift steps
// and the result handoff. Depends on ple_pkg.
module ple_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  ple_pkg::dp_status_t st,
  output ple_pkg::cmd_t      cmd
);

  ple_pkg::state_t state;
  ple_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ple_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = (state != ple_pkg::S_IDLE);
    case (state)
      ple_pkg::S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ple_pkg::S_EXEC;
        end
      end
      ple_pkg::S_EXEC: begin
        state_next      = ple_pkg::S_FINISH;
        cmd.set_status  = 1'b1;
        cmd.status_code = ple_pkg::ST_DONE;
        if (st.range_err) begin
          cmd.status_code = ple_pkg::ST_RANGE;
        end else begin
          case (st.op)
            ple_pkg::OP_READ: begin
              cmd.rd_issue = 1'b1;
            end
            ple_pkg::OP_REPLACE: begin
              cmd.word_write = 1'b1;
            end
            ple_pkg::OP_INSERT: begin
              if (st.full_err) begin
                cmd.status_code = ple_pkg::ST_FULL;
              end else begin
                cmd.init_k = 1'b1;
                state_next = ple_pkg::S_SHIFT_RD;
              end
            end
            ple_pkg::OP_DELETE: begin
              cmd.init_k = 1'b1;
              state_next = ple_pkg::S_SHIFT_RD;
            end
            default: begin
            end
          endcase
        end
      end
      ple_pkg::S_SHIFT_RD: begin
        if (st.more) begin
          cmd.rd_issue     = 1'b1;
          cmd.rd_sel_shift = 1'b1;
          state_next       = ple_pkg::S_SHIFT_WR;
        end else begin
          // The shift is complete; an insert still has to drop its word in.
          if (st.op == ple_pkg::OP_INSERT) begin
            cmd.word_write = 1'b1;
            cmd.count_inc  = 1'b1;
          end else begin
            cmd.count_dec = 1'b1;
          end
          state_next = ple_pkg::S_FINISH;
        end
      end
      ple_pkg::S_SHIFT_WR: begin
        cmd.shift_write = 1'b1;
        cmd.k_step      = 1'b1;
        state_next      = ple_pkg::S_SHIFT_RD;
      end
      ple_pkg::S_FINISH: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ple_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ple_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ple_dp.sv =====
// Datapath of the positional list engine: request register, list memory,
// shift index, word count and output register. Depends on ple_pkg.
module ple_dp #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ple_pkg::req_t      req,
  input  ple_pkg::cmd_t      cmd,
  output ple_pkg::dp_status_t st,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output ple_pkg::rsp_t      rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;
  localparam int RW = (CW > ple_pkg::COUNT_W) ? CW : ple_pkg::COUNT_W;

  logic signed [ple_pkg::WORD_W-1:0] mem [CAPACITY];

  ple_pkg::req_t                     cur;
  logic [CW-1:0]                     k;
  logic [CW-1:0]                     count;
  logic signed [ple_pkg::WORD_W-1:0] rd_data;
  ple_pkg::status_t                  res_status;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] k_x;
  logic [CW-1:0] k_dn;
  logic [CW-1:0] k_up;
  logic [CW-1:0] shift_src;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] pos_a;
  logic [AW-1:0] k_a;
  logic [RW-1:0] count_r;
  logic          is_insert;

  assign pos_x     = XW'(cur.position);
  assign cnt_x     = XW'(count);
  assign k_x       = XW'(k);
  assign k_dn      = k - CW'(1);
  assign k_up      = k + CW'(1);
  assign is_insert = (cur.op == ple_pkg::OP_INSERT);
  assign shift_src = is_insert ? k_dn : k_up;
  assign pos_a     = pos_x[AW-1:0];
  assign k_a       = k[AW-1:0];
  assign rd_addr   = cmd.rd_sel_shift ? shift_src[AW-1:0] : pos_a;
  assign count_r   = RW'(count);

  // An insert may append at the end; every other operation needs an existing word.
  assign st.op        = cur.op;
  assign st.range_err = is_insert ? (pos_x > cnt_x) : (pos_x >= cnt_x);
  assign st.full_err  = (count == CW'(CAPACITY));
  assign st.more      = is_insert ? (k_x > pos_x) : (k_up < count);
  assign st.out_free  = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      cur <= req;
    end
    if (cmd.init_k) begin
      k <= is_insert ? count : pos_x[CW-1:0];
    end else if (cmd.k_step) begin
      k <= is_insert ? k_dn : k_up;
    end
    if (cmd.set_status) begin
      res_status <= cmd.status_code;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_write) begin
      mem[k_a] <= rd_data;
    end else if (cmd.word_write) begin
      mem[pos_a] <= cur.word_in;
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.count_inc) begin
      count <= count + CW'(1);
    end else if (cmd.count_dec) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.word_out <= (cur.op == ple_pkg::OP_READ && res_status == ple_pkg::ST_DONE)
                      ? rd_data : '0;
      rsp.status   <= res_status;
      rsp.count    <= count_r[ple_pkg::COUNT_W-1:0];
    end
  end

endmodule

// ===== rtl/core/positional_list_engine.sv =====
// Top level of the positional list engine: controller plus datapath.
// Depends on ple_pkg, ple_ctrl and ple_dp.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------
//   request | req_valid | req_stall | req (op, position, word_in)
//   result  | rsp_valid | rsp_stall | rsp (word_out, status, count)
//
// One transaction is worked at a time. A read, a replace or a rejected request
// passes through the exec and finish states; an insert or a delete also shifts
// the words between its position and the end of the list, each word with a read
// in S_SHIFT_RD followed by a write in S_SHIFT_WR through the list memory.
// Reset empties the list; the memory contents are not cleared. While a result is
// stalled, the next one holds the finish state, and the request side stays stalled until it is taken.
module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ple_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ple_pkg::rsp_t rsp
);

  ple_pkg::cmd_t       cmd;
  ple_pkg::dp_status_t st;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  ple_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== tb/sv/positional_list_engine_checker.sv =====
`timescale 1ns / 100ps
// Checker for the positional list engine: watches both channels, keeps its own
// copy of the list and compares every result transaction. Depends on ple_pkg.
module positional_list_engine_checker #(
  parameter int CAP = ple_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic                          req_stall,
  input  ple_pkg::req_t                 req,
  input  logic                          rsp_valid,
  input  logic                          rsp_stall,
  input  ple_pkg::rsp_t                 rsp,
  output int                            errors,
  output int                            pending,
  output logic [ple_pkg::COUNT_W-1:0]   list_len,
  output int                            results_checked,
  output int                            range_hits,
  output int                            full_hits
);

  logic [ple_pkg::WORD_W-1:0] words [CAP];
  int                         used_words;
  ple_pkg::rsp_t              expected_results [$];

  task automatic report(string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    errors++;
  endtask

  // Applies one accepted request to the shadow list and returns its result.
  function automatic ple_pkg::rsp_t apply_request(ple_pkg::req_t r);
    ple_pkg::rsp_t res;
    int            p;
    res = '0;
    res.status = ple_pkg::ST_DONE;
    p = r.position;
    if (r.op == ple_pkg::OP_INSERT) begin
      if (p > used_words) begin
        res.status = ple_pkg::ST_RANGE;
      end else if (used_words >= CAP) begin
        res.status = ple_pkg::ST_FULL;
      end else begin
        for (int k = used_words; k > p; k--) words[k] = words[k-1];
        words[p] = r.word_in;
        used_words++;
      end
    end else if (p >= used_words) begin
      res.status = ple_pkg::ST_RANGE;
    end else begin
      case (r.op)
        ple_pkg::OP_READ: res.word_out = words[p];
        ple_pkg::OP_REPLACE: words[p] = r.word_in;
        default: begin
          for (int k = p; k + 1 < used_words; k++) words[k] = words[k+1];
          used_words--;
        end
      endcase
    end
    res.count = used_words[ple_pkg::COUNT_W-1:0];
    return res;
  endfunction

  task automatic check_result(ple_pkg::rsp_t got);
    ple_pkg::rsp_t want;
    if (expected_results.size() == 0) begin
      report($sformatf("result with nothing outstanding (word %0d, status %0d, count %0d)",
                       got.word_out, got.status, got.count));
      return;
    end
    want = expected_results.pop_front();
    results_checked++;
    if (got.word_out !== want.word_out)
      report($sformatf("result %0d word_out %0d, expected %0d",
                       results_checked, got.word_out, want.word_out));
    if (got.status !== want.status)
      report($sformatf("result %0d status %0d, expected %0d",
                       results_checked, got.status, want.status));
    if (got.count !== want.count)
      report($sformatf("result %0d count %0d, expected %0d",
                       results_checked, got.count, want.count));
  endtask

  always @(posedge clk) begin
    ple_pkg::rsp_t want;
    if (rst) begin
      used_words = 0;
      expected_results.delete();
    end else begin
      // A result leaving in this cycle always belongs to an earlier request.
      if (rsp_valid && !rsp_stall) check_result(rsp);
      if (req_valid && !req_stall) begin
        want = apply_request(req);
        if (want.status == ple_pkg::ST_RANGE) range_hits++;
        if (want.status == ple_pkg::ST_FULL) full_hits++;
        expected_results.push_back(want);
      end
    end
    pending  <= expected_results.size();
    list_len <= used_words[ple_pkg::COUNT_W-1:0];
  end

endmodule

// ===== tb/sv/positional_list_engine_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the positional list engine: clock, reset, request stimulus
// and result stall control. Depends on ple_pkg, the engine and its checker.
module positional_list_engine_tb;

  localparam int CAP              = ple_pkg::CAPACITY_DEF;
  localparam int HOLD_CYCLES      = 300;
  localparam int TAIL_CYCLES      = 50;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_PER_PHASE = 150;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        req_valid = 1'b0;
  ple_pkg::req_t               req       = '0;
  logic                        req_stall;
  logic                        rsp_valid;
  logic                        rsp_stall = 1'b0;
  ple_pkg::rsp_t               rsp;

  int                          send_idle_pct = 0;
  int                          stall_pct     = 0;
  logic                        long_hold     = 1'b0;
  int                          cycles        = 0;
  int                          sent          = 0;

  int                          errors;
  int                          pending;
  logic [ple_pkg::COUNT_W-1:0] list_len;
  int                          results_checked;
  int                          range_hits;
  int                          full_hits;

  positional_list_engine #(.CAPACITY(CAP)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  positional_list_engine_checker #(.CAP(CAP)) i_checker (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .req             (req),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .rsp             (rsp),
    .errors          (errors),
    .pending         (pending),
    .list_len        (list_len),
    .results_checked (results_checked),
    .range_hits      (range_hits),
    .full_hits       (full_hits)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stalls, or one long hold-off when the top asks for it.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold && !hold_done) begin
        hold_done = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic logic [ple_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offers one request transaction and returns at the edge that accepts it.
  task automatic put_item(ple_pkg::op_t op, int unsigned pos,
                          logic [ple_pkg::WORD_W-1:0] word);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req.op       <= op;
    req.position <= pos[ple_pkg::POS_W-1:0];
    req.word_in  <= word;
    req_valid    <= 1'b1;
    do @(posedge clk); while (req_stall);
    sent++;
  endtask

  task automatic wait_empty();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Bursts of inserts that fill the list, deletes that drain it, well-formed
  // mixes at valid positions, and some fully random noise.
  task automatic run_random(int n);
    int           issued;
    int           kind;
    int           len;
    int           lim;
    ple_pkg::op_t op;
    issued = 0;
    while (issued < n) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(3, 20);
      for (int i = 0; i < len && issued < n; i++) begin
        lim = list_len;
        case (kind)
          0, 1, 2: put_item(ple_pkg::OP_INSERT, $urandom_range(0, lim), pick_word());
          3, 4: put_item(ple_pkg::OP_DELETE,
                         (lim == 0) ? 0 : $urandom_range(0, lim - 1), pick_word());
          9: put_item(ple_pkg::op_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                      pick_word());
          default: begin
            op = ple_pkg::op_t'($urandom_range(0, 3));
            if (op == ple_pkg::OP_INSERT)
              put_item(op, $urandom_range(0, lim), pick_word());
            else
              put_item(op, (lim == 0) ? 0 : $urandom_range(0, lim - 1), pick_word());
          end
        endcase
        issued++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty list: everything but an append at the end is out of range.
    put_item(ple_pkg::OP_READ,    0, pick_word());
    put_item(ple_pkg::OP_REPLACE, 0, 32'h1234_5678);
    put_item(ple_pkg::OP_DELETE,  0, pick_word());
    put_item(ple_pkg::OP_INSERT,  1, 32'h0bad_0bad);
    put_item(ple_pkg::OP_INSERT,  0, 32'h7fff_ffff);
    put_item(ple_pkg::OP_INSERT,  1, 32'h8000_0000);
    put_item(ple_pkg::OP_INSERT,  0, 32'hffff_ffff);
    put_item(ple_pkg::OP_READ,    0, pick_word());
    put_item(ple_pkg::OP_READ,    1, pick_word());
    put_item(ple_pkg::OP_READ,    2, pick_word());
    put_item(ple_pkg::OP_READ,    3, pick_word());
    put_item(ple_pkg::OP_REPLACE, 1, 32'h0000_0000);
    put_item(ple_pkg::OP_READ,    1, pick_word());
    put_item(ple_pkg::OP_DELETE,  0, pick_word());
    put_item(ple_pkg::OP_READ,    0, pick_word());
    put_item(ple_pkg::OP_DELETE,  1, pick_word());
    put_item(ple_pkg::OP_READ,    31, pick_word());
    put_item(ple_pkg::OP_INSERT,  31, 32'h5555_aaaa);
    put_item(ple_pkg::OP_REPLACE, 16, 32'haaaa_5555);
    put_item(ple_pkg::OP_DELETE,  0, pick_word());
    put_item(ple_pkg::OP_READ,    0, pick_word());
    wait_empty();

    // No idling, then a long result hold-off while requests keep coming.
    stall_pct <= 0;
    run_random(RANDOM_PER_PHASE);
    long_hold <= 1'b1;
    run_random(20);
    wait_empty();

    send_idle_pct = 63;
    run_random(RANDOM_PER_PHASE);

    send_idle_pct = 0;
    stall_pct <= 63;
    run_random(RANDOM_PER_PHASE);

    send_idle_pct = 31;
    stall_pct <= 31;
    run_random(RANDOM_PER_PHASE);

    wait_empty();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Drove %0d requests through four idle and stall mixes and one long hold-off.",
             sent);
    $display("Checked %0d results: %0d out of range, %0d rejected with the list full.",
             results_checked, range_hits, full_hits);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
